>>> rtl/assert_macros.svh
// Assertion macros used by the keyboard decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset
`define SCQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in keyboard decoder");

// Next-cycle implication, checked at every clock edge outside reset
`define SCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in keyboard decoder");

`endif

>>> rtl/scq_pkg.sv
// Shared types and constants for the scancode to character queue
package scq_pkg;

   localparam int QUEUE_DEPTH  = 128;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LAYOUT_DEPTH = 256;
   localparam int LAYOUT_AW    = 8;

   localparam logic [7:0] SC_PREFIX = 8'hE0;
   localparam logic [6:0] SC_LSHIFT = 7'h2A;
   localparam logic [6:0] SC_RSHIFT = 7'h36;
   localparam logic [6:0] SC_CAPS   = 7'h3A;
   localparam logic [7:0] CASE_FLIP = 8'h20;

   typedef enum logic [1:0] {
      OP_SCAN = 2'd0,
      OP_LOAD = 2'd1,
      OP_POP  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Per-request control produced at accept time
   typedef struct packed {
      logic lookup;
      logic pop;
      logic caps;
   } ctl_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } qcmd_type;

   typedef struct packed {
      logic full;
      logic nonempty;
      logic has_next;
   } qstat_type;

endpackage

>>> rtl/scq_decode.sv
// Scancode prefix, shift and caps lock tracking, and lookup classification
module scq_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [1:0]                       op,
   input  logic                             from_aux,
   input  logic [7:0]                       scan_byte,
   output scq_pkg::ctl_type                 ctl,
   output logic [scq_pkg::LAYOUT_AW-1:0]    lookup_addr
);

   logic prefix_ff, prefix_in;
   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic is_shift;
   logic lookup;
   logic is_scan;

   assign is_shift = (scan_byte[6:0] == scq_pkg::SC_LSHIFT) ||
                     (scan_byte[6:0] == scq_pkg::SC_RSHIFT);

   always_comb begin
      prefix_in = prefix_ff;
      shift_in  = shift_ff;
      caps_in   = caps_ff;
      lookup    = 1'b0;
      is_scan   = 1'b0;
      case (scq_pkg::op_type'(op))
         scq_pkg::OP_SCAN: is_scan = !from_aux;
         default:          is_scan = 1'b0;
      endcase
      if (is_scan) begin
         if (scan_byte == scq_pkg::SC_PREFIX) begin
            prefix_in = 1'b1;
         end else if (scan_byte[7]) begin
            // break: release shift only when not prefixed
            if (!prefix_ff && is_shift) begin
               shift_in = 1'b0;
            end
            prefix_in = 1'b0;
         end else if (prefix_ff) begin
            prefix_in = 1'b0;
         end else if (is_shift) begin
            shift_in = 1'b1;
         end else if (scan_byte[6:0] == scq_pkg::SC_CAPS) begin
            caps_in = ~caps_ff;
         end else begin
            lookup = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
         shift_ff  <= 1'b0;
         caps_ff   <= 1'b0;
      end else if (accept) begin
         prefix_ff <= prefix_in;
         shift_ff  <= shift_in;
         caps_ff   <= caps_in;
      end
   end

   assign ctl.lookup  = lookup;
   assign ctl.pop     = (scq_pkg::op_type'(op) == scq_pkg::OP_POP);
   assign ctl.caps    = caps_ff;
   assign lookup_addr = {shift_ff, scan_byte[6:0]};

endmodule

>>> rtl/scq_layout.sv
// Layout table memory with per-entry valid bits so reset reads as empty
module scq_layout (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic                             rd_en,
   input  logic [scq_pkg::LAYOUT_AW-1:0]    addr,
   input  logic [7:0]                       wr_data,
   output logic [7:0]                       rd_data
);

   logic [7:0]                        mem [scq_pkg::LAYOUT_DEPTH];
   logic [scq_pkg::LAYOUT_DEPTH-1:0]  valid_ff;
   logic [7:0]                        data_ff;
   logic                              ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[addr];
         ok_ff   <= valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign rd_data = ok_ff ? data_ff : 8'd0;

endmodule

>>> rtl/scq_queue.sv
// Character ring queue: one memory, read and write pointers
`include "assert_macros.svh"

module scq_queue (
   input  logic                clock,
   input  logic                reset,
   input  scq_pkg::qcmd_type   cmd,
   output scq_pkg::qstat_type  stat,
   output logic [7:0]          rd_data
);

   logic [7:0]                 mem [scq_pkg::QUEUE_DEPTH];
   logic [scq_pkg::QPTR_W-1:0] rp_ff, rp_in;
   logic [scq_pkg::QPTR_W-1:0] wp_ff, wp_in;
   logic [scq_pkg::QPTR_W-1:0] rp_next, wp_next;
   logic [7:0]                 rd_ff;
   logic                       push_fire;
   logic                       pop_fire;

   localparam logic [scq_pkg::QPTR_W-1:0] LAST = scq_pkg::QPTR_W'(scq_pkg::QUEUE_DEPTH - 1);

   assign rp_next = (rp_ff == LAST) ? '0 : rp_ff + 1'b1;
   assign wp_next = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;

   assign stat.full     = (wp_next == rp_ff);
   assign stat.nonempty = (rp_ff != wp_ff);

   assign push_fire = cmd.push && !stat.full;
   assign pop_fire  = cmd.pop && stat.nonempty;

   always_comb begin
      rp_in = rp_ff;
      wp_in = wp_ff;
      if (push_fire) begin
         wp_in = wp_next;
      end
      if (pop_fire) begin
         rp_in = rp_next;
      end
   end

   assign stat.has_next = (rp_in != wp_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= '0;
         wp_ff <= '0;
      end else begin
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem[wp_ff] <= cmd.data;
      end
      if (pop_fire) begin
         rd_ff <= mem[rp_ff];
      end
   end

   assign rd_data = rd_ff;

   `SCQ_ASSERT_NOW(a_full_not_empty, clock, reset, stat.full, stat.nonempty)
   `SCQ_ASSERT_NEXT(a_push_fills, clock, reset, push_fire, stat.nonempty)
   `SCQ_ASSERT_NEXT(a_idle_holds, clock, reset, !push_fire && !pop_fire,
                    $stable(rp_ff) && $stable(wp_ff))

endmodule

>>> rtl/scancode_to_char_queue.sv
// Top level of the set 1 scancode decoder with character queue
// Takes one request per clock with no bubbles while rsp_tready stays high;
// rsp_tvalid for a request is registered: the layout is read at accept into
// the lookup stage; the queue update follows when it moves on. While a result
// waits on rsp_tready, one more request is taken into the lookup stage and
// then req_tready drops until the result is taken. Rate is set by the
// single port of the layout table (read or written at accept) and the queue
// memory (one push or one pop per cycle in the second stage). The layout
// table comes out of reset empty at once through per-entry valid bits; there
// is no clearing pass. The queue holds at most QUEUE_DEPTH-1 characters; a
// character decoded into a full queue is dropped and flagged.
module scancode_to_char_queue (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: scan_byte[7:0], table_shifted[8], table_index[15:9], table_char[23:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // req_tuser: op[1:0], from_aux[2]
   input  logic [2:0]  req_tuser,
   // rsp_tdata: char_out[7:0], char_valid[8], has_char[9], dropped[10], zero[15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic                           accept;
   logic                           is_load;
   logic                           s1_en, s2_en, s1_move;
   logic                           s1_valid_ff, s1_valid_in;
   scq_pkg::ctl_type               s1_ctl_ff;
   scq_pkg::ctl_type               dec_ctl;
   logic [scq_pkg::LAYOUT_AW-1:0]  dec_addr;
   logic [scq_pkg::LAYOUT_AW-1:0]  lay_addr;
   logic [7:0]                     lay_data;
   logic [7:0]                     ch;
   logic                           ch_ok;
   scq_pkg::qcmd_type              qcmd;
   scq_pkg::qstat_type             qstat;
   logic [7:0]                     q_data;
   logic                           enable_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           char_valid_ff;
   logic                           has_char_ff;
   logic                           dropped_ff;

   assign s2_en      = !rsp_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign s1_move    = s1_valid_ff && s2_en;
   assign req_tready = s1_en;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // table entry address: shifted half select on top, make code below
   assign is_load  = (scq_pkg::op_type'(req_tuser[1:0]) == scq_pkg::OP_LOAD);
   assign lay_addr = is_load ? {req_tdata[8], req_tdata[15:9]} : dec_addr;

   scq_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_tuser[1:0]),
      .from_aux    (req_tuser[2]),
      .scan_byte   (req_tdata[7:0]),
      .ctl         (dec_ctl),
      .lookup_addr (dec_addr)
   );

   scq_layout u_layout (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && is_load),
      .rd_en   (accept),
      .addr    (lay_addr),
      .wr_data (req_tdata[23:16]),
      .rd_data (lay_data)
   );

   // caps lock swaps the case of ASCII letters only
   always_comb begin
      ch = lay_data;
      if (s1_ctl_ff.caps) begin
         if (lay_data inside {[8'h61:8'h7A]}) begin
            ch = lay_data - scq_pkg::CASE_FLIP;
         end else if (lay_data inside {[8'h41:8'h5A]}) begin
            ch = lay_data + scq_pkg::CASE_FLIP;
         end
      end
   end

   assign ch_ok     = s1_ctl_ff.lookup && enable_ff && (lay_data != 8'd0);
   assign qcmd.push = s1_move && ch_ok;
   assign qcmd.pop  = s1_move && s1_ctl_ff.pop;
   assign qcmd.data = ch;

   scq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (qcmd),
      .stat    (qstat),
      .rd_data (q_data)
   );

   assign s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= dec_ctl;
      end
      if (s1_move) begin
         char_valid_ff <= s1_ctl_ff.pop && qstat.nonempty;
         has_char_ff   <= qstat.has_next;
         dropped_ff    <= ch_ok && qstat.full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, dropped_ff, has_char_ff, char_valid_ff,
                        (char_valid_ff ? q_data : 8'd0)};

endmodule
